// ===== sv/idp_pkg.sv =====
`timescale 1ns / 1ps

package idp_pkg;

  // Fixed sample and accumulator widths.
  localparam int SAMPLE_BITS   = 8;
  localparam int SUM_BITS      = 14;
  localparam int MAX_WIDTH_DEF = 32;

  // Register indexes on the configuration port (byte address bit 2).
  localparam logic REG_SIZE_LOG2   = 1'b0;
  localparam logic REG_EDGE_FILTER = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_PREP,
    ST_ROWS
  } idp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_word;
    logic prep;
    logic load_row;
  } idp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_word;
    logic last_row;
  } idp_status_t;

endpackage

// ===== sv/idp_controller.sv =====
`timescale 1ns / 1ps

module idp_controller
  import idp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  idp_status_t status,
  output idp_cmd_t    cmd
);

  idp_state_t state;
  idp_state_t state_next;
  logic       load;

  // The output register can take a new row when it is empty or being drained.
  assign load = !out_valid || !out_stall;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_row) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (in_valid && status.final_word) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_ROWS;
      end
      ST_ROWS: begin
        if (load && status.last_row) begin
          state_next = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  // Commands and input stall.
  always_comb begin
    in_stall      = 1'b1;
    cmd.take_word = 1'b0;
    cmd.prep      = 1'b0;
    cmd.load_row  = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_stall      = 1'b0;
        cmd.take_word = in_valid;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_ROWS: begin
        cmd.load_row = load;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/idp_datapath.sv =====
`timescale 1ns / 1ps

module idp_datapath
  import idp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  idp_cmd_t               cmd,
  output idp_status_t            status,
  input  logic [2:0]             size_log2,
  input  logic                   edge_filter_on,
  input  logic [SAMPLE_BITS-1:0] top_even,
  input  logic [SAMPLE_BITS-1:0] top_odd,
  input  logic [SAMPLE_BITS-1:0] left_even,
  input  logic [SAMPLE_BITS-1:0] left_odd,
  output logic [63:0]            pixels_0_7,
  output logic [63:0]            pixels_8_15,
  output logic [63:0]            pixels_16_23,
  output logic [63:0]            pixels_24_31,
  output logic [4:0]             row_index,
  output logic                   last_row
);

  localparam int KW       = $clog2(MAX_WIDTH + 1);
  localparam int PW       = $clog2(MAX_WIDTH);
  localparam int LOG2_MAX = $clog2(MAX_WIDTH + 1) - 1;

  // Reference stores hold sample indexes 1..MAX_WIDTH at position index-1.
  logic [SAMPLE_BITS-1:0] top_store  [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] left_store [MAX_WIDTH];

  logic [SUM_BITS-1:0]    running_sum;
  logic [KW-1:0]          word_count;
  logic [PW-1:0]          row;
  logic [SAMPLE_BITS-1:0] dc;
  logic [9:0]             dc2;
  logic [9:0]             dc3;
  logic [2:0]             blk_sl;
  logic                   blk_filt;
  logic [255:0]           out_pix;

  logic [2:0]             sl_cur;
  logic [6:0]             w_cur;
  logic [6:0]             blk_w;
  logic [6:0]             idx_e;
  logic [6:0]             idx_o;
  logic                   we_e;
  logic                   we_o;
  logic [PW-1:0]          pos_e;
  logic [PW-1:0]          pos_o;
  logic [SUM_BITS-1:0]    add_e;
  logic [SUM_BITS-1:0]    add_o;
  logic [SUM_BITS-1:0]    sum_next;
  logic [SUM_BITS:0]      sum_w;
  logic [SAMPLE_BITS-1:0] dc_calc;
  logic [255:0]           row_pix;
  logic [9:0]             left_acc;

  // Effective block size: clamp to the supported range and to MAX_WIDTH.
  always_comb begin
    if (size_log2 < 3'd2) begin
      sl_cur = 3'd2;
    end else if (size_log2 > 3'd5) begin
      sl_cur = 3'd5;
    end else begin
      sl_cur = size_log2;
    end
    if (sl_cur > 3'(LOG2_MAX)) begin
      sl_cur = 3'(LOG2_MAX);
    end
  end

  assign w_cur = 7'd1 << sl_cur;
  assign blk_w = 7'd1 << blk_sl;

  // A word whose index reaches the width closes the block.
  assign status.final_word = 7'(word_count) >= w_cur;
  assign status.last_row   = ({1'b0, row} + (PW+1)'(1)) == (PW+1)'(blk_w);

  // Sample indexes carried by the current word.
  assign idx_e = 7'(word_count) << 1;
  assign idx_o = idx_e + 7'd1;
  assign pos_e = PW'(idx_e - 7'd1);
  assign pos_o = PW'(idx_o - 7'd1);
  assign we_e  = cmd.take_word && (idx_e >= 7'd1) && (idx_e <= 7'(MAX_WIDTH));
  assign we_o  = cmd.take_word && !status.final_word && (idx_o <= 7'(MAX_WIDTH));

  // Only indexes 1..width enter the sum; the closing word adds nothing.
  always_comb begin
    add_e = '0;
    add_o = '0;
    if (!status.final_word && (idx_e >= 7'd1) && (idx_e <= w_cur)) begin
      add_e = SUM_BITS'(top_even) + SUM_BITS'(left_even);
    end
    if (!status.final_word && (idx_o <= w_cur)) begin
      add_o = SUM_BITS'(top_odd) + SUM_BITS'(left_odd);
    end
  end

  assign sum_next = running_sum + add_e + add_o;

  // DC value from the finished sum with rounding.
  assign sum_w   = {1'b0, running_sum} + (SUM_BITS+1)'(w_cur);
  assign dc_calc = SAMPLE_BITS'(sum_w >> (sl_cur + 3'd1));

  // Accumulator, word counter and row counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      word_count  <= '0;
      row         <= '0;
    end else begin
      if (cmd.take_word) begin
        if (status.final_word) begin
          running_sum <= '0;
          word_count  <= '0;
        end else begin
          running_sum <= sum_next;
          word_count  <= word_count + KW'(1);
        end
      end
      if (cmd.prep) begin
        row <= '0;
      end else if (cmd.load_row) begin
        row <= row + PW'(1);
      end
    end
  end

  // Block parameters, DC terms and output row payload.
  always_ff @(posedge clk) begin
    if (cmd.take_word && status.final_word) begin
      dc       <= dc_calc;
      blk_sl   <= sl_cur;
      blk_filt <= edge_filter_on;
    end
    if (cmd.prep) begin
      dc2 <= (10'(dc) << 1) + 10'd2;
      dc3 <= 10'(dc) + (10'(dc) << 1) + 10'd2;
    end
    if (cmd.load_row) begin
      out_pix   <= row_pix;
      row_index <= 5'(row);
      last_row  <= status.last_row;
    end
  end

  // Reference sample stores.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (we_e && (pos_e == PW'(i))) begin
        top_store[i]  <= top_even;
        left_store[i] <= left_even;
      end else if (we_o && (pos_o == PW'(i))) begin
        top_store[i]  <= top_odd;
        left_store[i] <= left_odd;
      end
    end
  end

  // Filtered first-column pixel for the current row.
  assign left_acc = 10'(left_store[row]) + dc3;

  // Pixels of the current row.
  for (genvar x = 0; x < 32; x++) begin : g_pix
    if (x < MAX_WIDTH) begin : g_used
      logic [9:0]             acc;
      logic [SAMPLE_BITS-1:0] p;
      always_comb begin
        if (x == 0) begin
          acc = 10'(top_store[0]) + 10'(left_store[0]) + dc2;
        end else begin
          acc = 10'(top_store[x]) + dc3;
        end
        if (7'(x) >= blk_w) begin
          p = '0;
        end else if (blk_filt && (row == '0)) begin
          p = acc[9:2];
        end else if (blk_filt && (x == 0)) begin
          p = left_acc[9:2];
        end else begin
          p = dc;
        end
      end
      assign row_pix[8*x +: 8] = p;
    end else begin : g_unused
      assign row_pix[8*x +: 8] = '0;
    end
  end

  assign pixels_0_7   = out_pix[63:0];
  assign pixels_8_15  = out_pix[127:64];
  assign pixels_16_23 = out_pix[191:128];
  assign pixels_24_31 = out_pix[255:192];

endmodule

// ===== sv/intra_dc_predictor.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Beat contents
// input     in_valid / in_stall  top_even, top_odd, left_even, left_odd
// output    out_valid/out_stall  pixels_0_7..pixels_24_31, row_index, last_row
// config    APB, pready high     size_log2 at 0x0, edge_filter_on at 0x4
//
// A block of width w takes w+1 input beats at one per cycle, one state to form
// the filter terms, then w row beats at one per cycle while out_stall is low.
// The input stalls from the closing beat until the last row sits in the output
// register, that is, while the row sequencer runs.
// Output stall holds the row register and pauses the row sequencer.
// Synchronous reset clears the sum, the word count and the sequencer; the
// sample stores are not cleared.

module intra_dc_predictor
  import idp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] top_even,
  input  logic [SAMPLE_BITS-1:0] top_odd,
  input  logic [SAMPLE_BITS-1:0] left_even,
  input  logic [SAMPLE_BITS-1:0] left_odd,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            pixels_0_7,
  output logic [63:0]            pixels_8_15,
  output logic [63:0]            pixels_16_23,
  output logic [63:0]            pixels_24_31,
  output logic [4:0]             row_index,
  output logic                   last_row
);

  logic [2:0]  size_log2;
  logic        edge_filter_on;
  logic        cfg_write;
  idp_cmd_t    cmd;
  idp_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2      <= 3'd2;
      edge_filter_on <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SIZE_LOG2:   size_log2      <= pwdata[2:0];
        REG_EDGE_FILTER: edge_filter_on <= pwdata[0];
        default:         size_log2      <= size_log2;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_SIZE_LOG2:   prdata = {29'd0, size_log2};
      REG_EDGE_FILTER: prdata = {31'd0, edge_filter_on};
      default:         prdata = '0;
    endcase
  end

  idp_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  idp_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .size_log2      (size_log2),
    .edge_filter_on (edge_filter_on),
    .top_even       (top_even),
    .top_odd        (top_odd),
    .left_even      (left_even),
    .left_odd       (left_odd),
    .pixels_0_7     (pixels_0_7),
    .pixels_8_15    (pixels_8_15),
    .pixels_16_23   (pixels_16_23),
    .pixels_24_31   (pixels_24_31),
    .row_index      (row_index),
    .last_row       (last_row)
  );

endmodule
